@@ rtl/bsf_pkg.sv @@
package bsf_pkg;

   localparam int unsigned PACKET_BYTES = 64;
   localparam int unsigned FILL_W = 7;
   localparam logic [7:0] START_BYTE = 8'hEE;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_BEGIN   = 2'd0,
      OP_PAYLOAD = 2'd1,
      OP_END     = 2'd2
   } op_type;

   // result slots of one request, emitted lowest bit first
   localparam int unsigned SLOT_END      = 0;
   localparam int unsigned SLOT_START    = 1;
   localparam int unsigned SLOT_CODE     = 2;
   localparam int unsigned SLOT_CODE_DUP = 3;
   localparam int unsigned SLOT_DATA     = 4;
   localparam int unsigned SLOT_DATA_DUP = 5;
   localparam int unsigned SLOTS         = 6;

   typedef logic [SLOTS-1:0] slot_mask_type;

   typedef struct packed {
      slot_mask_type slots;
      logic [7:0]    code;
      logic [7:0]    data;
   } desc_type;

endpackage

@@ rtl/bsf_front.sv @@
module bsf_front
   import bsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       accept,
   input  logic [1:0] operation,
   input  logic [7:0] command_code,
   input  logic [7:0] payload_byte,
   output logic       push,
   output desc_type   push_desc
);

   localparam logic [FILL_W:0] LIMIT = (FILL_W+1)'(PACKET_BYTES);

   logic [7:0]        cont_code_ff;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              open_ff, open_in;
   logic [FILL_W:0]   sum;
   logic [FILL_W-1:0] need;
   logic [FILL_W-1:0] cont_len;
   logic              wants;

   always_comb begin
      need     = (payload_byte == START_BYTE) ? FILL_W'(2) : FILL_W'(1);
      cont_len = (cont_code_ff == START_BYTE) ? FILL_W'(3) : FILL_W'(2);
      sum      = {1'b0, fill_ff} + {1'b0, need};
      fill_in  = fill_ff;
      open_in  = open_ff;
      wants    = 1'b0;
      push_desc.slots = '0;
      push_desc.code  = command_code;
      push_desc.data  = payload_byte;
      case (op_type'(operation))
         OP_BEGIN: begin
            wants = 1'b1;
            push_desc.slots[SLOT_END]      = open_ff;
            push_desc.slots[SLOT_START]    = 1'b1;
            push_desc.slots[SLOT_CODE]     = 1'b1;
            push_desc.slots[SLOT_CODE_DUP] = (command_code == START_BYTE);
            fill_in = (command_code == START_BYTE) ? FILL_W'(3) : FILL_W'(2);
            open_in = 1'b1;
         end
         OP_PAYLOAD: begin
            if (open_ff) begin
               wants = 1'b1;
               push_desc.slots[SLOT_DATA]     = 1'b1;
               push_desc.slots[SLOT_DATA_DUP] = (payload_byte == START_BYTE);
               if (sum > LIMIT) begin
                  push_desc.code = cont_code_ff;
                  push_desc.slots[SLOT_END]      = 1'b1;
                  push_desc.slots[SLOT_START]    = 1'b1;
                  push_desc.slots[SLOT_CODE]     = 1'b1;
                  push_desc.slots[SLOT_CODE_DUP] = (cont_code_ff == START_BYTE);
                  fill_in = cont_len + need;
               end else begin
                  fill_in = sum[FILL_W-1:0];
               end
            end
         end
         OP_END: begin
            if (open_ff) begin
               wants = 1'b1;
               push_desc.slots[SLOT_END] = 1'b1;
               fill_in = '0;
               open_in = 1'b0;
            end
         end
         default: begin
            wants = 1'b0;
         end
      endcase
      push = accept & wants;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_code_ff <= '0;
         fill_ff      <= '0;
         open_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            cont_code_ff <= csr_wdata;
         end
         if (accept) begin
            fill_ff <= fill_in;
            open_ff <= open_in;
         end
      end
   end

endmodule

@@ rtl/bsf_queue.sv @@
module bsf_queue
   import bsf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output desc_type head
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   desc_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full      = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/bsf_back.sv @@
module bsf_back
   import bsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  desc_type   q_head,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   slot_mask_type slots_ff, slots_in, sel, rest;
   logic [7:0]    code_ff, data_ff;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff, byte_in;
   logic          end_ff, end_in;
   logic          last_ff, last_in;
   logic          adv;
   logic          load;

   always_comb begin
      adv  = !valid_ff || rsp_tready;
      sel  = slots_ff & (~slots_ff + 1'b1);
      rest = slots_ff & ~sel;
      load = (slots_ff == '0) || (adv && (rest == '0));
      q_pop = load && q_not_empty;

      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      if (adv) begin
         valid_in = (slots_ff != '0);
         last_in  = (rest == '0);
         end_in   = sel[SLOT_END];
         if (sel[SLOT_START]) begin
            byte_in = START_BYTE;
         end else if (sel[SLOT_CODE] || sel[SLOT_CODE_DUP]) begin
            byte_in = code_ff;
         end else if (sel[SLOT_DATA] || sel[SLOT_DATA_DUP]) begin
            byte_in = data_ff;
         end else begin
            byte_in = '0;
         end
      end

      if (q_pop) begin
         slots_in = q_head.slots;
      end else if (adv) begin
         slots_in = rest;
      end else begin
         slots_in = slots_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         slots_ff <= slots_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         code_ff <= q_head.code;
         data_ff <= q_head.data;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = end_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/byte_stuffing_packet_framer.sv @@
// Byte-stuffing packet framer.
// Request channel (req_*): one command step per request; tuser carries the
// operation (begin, payload byte, end), tdata the command code and payload byte.
// Result channel (rsp_*): one byte or packet-end marker per transfer; tuser high
// marks a packet end (tdata zero), tlast marks the final result of a request.
// csr_we/csr_wdata write the continuation code; the user must write it only
// while the block is idle, which the block does not enforce. Each request
// expands into 0 to 6 results. The front end tracks packet fill and emits a
// descriptor into a two-entry queue; the back end expands it at one result per
// cycle, while the receiver is ready, into an output register.
// Throughput: one request per cycle while the queue has room; sustained rate
// is set by the back end and the number of results each request expands into.
// Reset clears fill count, open-command flag, queue and continuation code.
// A stalled receiver holds the output register; the queue fills and then
// req_tready drops until the back end drains.
module byte_stuffing_packet_framer
   import bsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] command_code, [15:8] payload_byte
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] tx_byte
   output logic        rsp_tuser,   // [0] packet_end
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   logic     accept;
   logic     push;
   desc_type push_desc;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   desc_type q_head;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   bsf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .operation    (req_tuser),
      .command_code (req_tdata[7:0]),
      .payload_byte (req_tdata[15:8]),
      .push         (push),
      .push_desc    (push_desc)
   );

   bsf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   bsf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ dv/bsf_checker.sv @@
`timescale 1ns / 100ps

module bsf_checker
   import bsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] command_code, [15:8] payload_byte
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] tx_byte
   input  logic        rsp_tuser,   // [0] packet_end
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output int          mismatch_count,
   output int          tx_pending
);

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       packet_end;
      logic       last;
   } tx_result_type;

   tx_result_type     tx_expected[$];
   logic [8:0]        step_buf[SLOTS];
   int                step_len;
   logic [7:0]        cont_code;
   logic [FILL_W-1:0] fill_level;
   logic              cmd_open;

   task automatic emit(input logic [7:0] b, input logic pe);
      step_buf[step_len] = {b, pe};
      step_len++;
   endtask

   task automatic emit_stuffed(input logic [7:0] b);
      emit(b, 1'b0);
      fill_level++;
      if (b == START_BYTE) begin
         emit(b, 1'b0);
         fill_level++;
      end
   endtask

   task automatic open_packet(input logic [7:0] code);
      emit(START_BYTE, 1'b0);
      fill_level = FILL_W'(1);
      emit_stuffed(code);
   endtask

   // expands one request into its framed bytes and end markers
   task automatic frame_step(input logic [1:0] op, input logic [7:0] code,
                             input logic [7:0] data);
      int need;
      step_len = 0;
      case (op)
         OP_BEGIN: begin
            if (cmd_open) emit(8'h00, 1'b1);
            open_packet(code);
            cmd_open = 1'b1;
         end
         OP_PAYLOAD: begin
            if (cmd_open) begin
               need = (data == START_BYTE) ? 2 : 1;
               if (int'(fill_level) + need > int'(PACKET_BYTES)) begin
                  emit(8'h00, 1'b1);
                  open_packet(cont_code);
               end
               emit_stuffed(data);
            end
         end
         OP_END: begin
            if (cmd_open) begin
               emit(8'h00, 1'b1);
               cmd_open = 1'b0;
               fill_level = '0;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < step_len; i++)
         tx_expected.push_back(tx_result_type'({step_buf[i], i == step_len - 1}));
   endtask

   always @(posedge clock) begin : monitor
      tx_result_type exp_r;
      if (reset) begin
         cont_code = '0;
         fill_level = '0;
         cmd_open = 1'b0;
         mismatch_count = 0;
         tx_expected.delete();
      end else begin
         if (csr_we) cont_code = csr_wdata;
         if (req_tvalid && req_tready)
            frame_step(req_tuser, req_tdata[7:0], req_tdata[15:8]);
         if (rsp_tvalid && rsp_tready) begin
            if (tx_expected.size() == 0) begin
               $error("unexpected result: tx_byte %h packet_end %b last %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               exp_r = tx_expected.pop_front();
               if (rsp_tdata !== exp_r.tx_byte) begin
                  $error("tx_byte: expected %h, got %h", exp_r.tx_byte, rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== exp_r.packet_end) begin
                  $error("packet_end: expected %b, got %b", exp_r.packet_end, rsp_tuser);
                  mismatch_count++;
               end
               if (rsp_tlast !== exp_r.last) begin
                  $error("last: expected %b, got %b", exp_r.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
      end
      tx_pending = tx_expected.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import bsf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [7:0]  csr_wdata;

   int mismatch_count;
   int tx_pending;
   int cycle_count;
   int burst_left = 0;
   int sent_count = 0;
   bit stim_open = 1'b0;
   bit hold_off_go = 1'b0;

   always #5 clock = ~clock;

   byte_stuffing_packet_framer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   bsf_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .tx_pending     (tx_pending)
   );

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic [1:0] op, input logic [7:0] code,
                               input logic [7:0] data);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser = op;
      req_tdata = {data, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_BEGIN || ((op == OP_PAYLOAD || op == OP_END) && stim_open))
         sent_count++;
      if (op == OP_BEGIN) stim_open = 1'b1;
      else if (op == OP_END) stim_open = 1'b0;
      @(negedge clock);
   endtask

   // one command with random payload, or a stray request
   task automatic send_sequence();
      int         len;
      int         ee_mode;
      logic [7:0] b;
      if ($urandom_range(0, 6) == 0) begin
         send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end else begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 140) : $urandom_range(0, 12);
         ee_mode = $urandom_range(0, 3);
         send_request(OP_BEGIN, ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom),
                      8'($urandom));
         for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (ee_mode == 1 || (ee_mode >= 2 && $urandom_range(0, 3) == 0)) b = START_BYTE;
            send_request(OP_PAYLOAD, 8'($urandom), b);
         end
         // some commands are left open, so a later begin or a stray end closes them
         if ($urandom_range(0, 4) != 0) send_request(OP_END, 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic settle();
      req_tvalid = 1'b0;
      while (tx_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(input logic [7:0] value);
      csr_we = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // receiver: random and regular stall patterns, plus one long hold-off
   initial begin
      int mode;
      int span;
      bit held;
      rsp_tready = 1'b0;
      mode = 0;
      span = 0;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !held) begin
            rsp_tready = 1'b0;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(negedge clock);
            held = 1'b1;
         end
         if (span == 0) begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
         end
         span--;
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            2: rsp_tready = ($urandom_range(0, 1) != 0);
            default: rsp_tready = (span % 4 != 0);
         endcase
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("byte_stuffing_packet_framer test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      write_csr(8'hFF);
      // requests with no command open are dropped
      send_request(OP_PAYLOAD, 8'h00, 8'h5A);
      send_request(OP_END, 8'hFF, 8'hFF);
      send_request(2'd3, 8'hFF, 8'hFF);
      send_request(OP_BEGIN, START_BYTE, 8'h00);
      send_request(OP_PAYLOAD, 8'hFF, 8'h00);
      send_request(OP_PAYLOAD, 8'h00, 8'hFF);
      send_request(OP_PAYLOAD, 8'h00, START_BYTE);
      send_request(2'd3, 8'h12, 8'h34);
      send_request(OP_BEGIN, 8'h00, 8'hFF);
      send_request(OP_PAYLOAD, 8'h00, START_BYTE);
      send_request(OP_END, 8'h00, 8'h00);
      send_request(OP_END, 8'h00, 8'h00);
      send_request(OP_BEGIN, 8'hFF, 8'h00);
      send_request(OP_PAYLOAD, 8'h00, 8'h7F);
      send_request(OP_END, 8'h00, 8'h00);
      settle();

      write_csr(8'h00);
      // doubled bytes fill the packet exactly, then spill into a continuation
      send_request(OP_BEGIN, 8'h3C, 8'h00);
      for (int i = 0; i < 33; i++) send_request(OP_PAYLOAD, 8'h00, START_BYTE);
      send_request(OP_END, 8'h00, 8'h00);
      while (sent_count < 150) send_sequence();
      settle();

      write_csr(START_BYTE);
      // one slot left when a doubled byte arrives
      send_request(OP_BEGIN, 8'h01, 8'h00);
      for (int i = 0; i < 61; i++) send_request(OP_PAYLOAD, 8'h00, 8'h00);
      send_request(OP_PAYLOAD, 8'h00, START_BYTE);
      send_request(OP_PAYLOAD, 8'h00, 8'h11);
      send_request(OP_END, 8'h00, 8'h00);
      while (sent_count < 295) send_sequence();
      settle();

      write_csr(8'($urandom_range(1, 254)));
      hold_off_go = 1'b1;
      while (sent_count < 385) send_sequence();
      settle();

      if (mismatch_count == 0)
         $display("byte_stuffing_packet_framer test passed");
      else
         $display("byte_stuffing_packet_framer test failed");
      $finish;
   end

endmodule
